// File: rtl/core/backlight_power_estimator_macros.svh
// assertion macros for the backlight power estimator
// used by the top level only; no other dependencies
`ifndef BACKLIGHT_POWER_ESTIMATOR_MACROS_SVH
`define BACKLIGHT_POWER_ESTIMATOR_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define BPE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("backlight power estimator check failed");
// expression must never be true out of reset
`define BPE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("backlight power estimator forbidden condition");
`else
`define BPE_ASSERT(lbl, clk, rst_n, prop)
`define BPE_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: rtl/core/bpe_pkg.sv
// shared types, constants and lookup tables of the backlight power estimator
// no dependencies
package bpe_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF   = 16;
  localparam int unsigned TABLE_STEP_DEF      = 273;
  localparam int unsigned DRIVER_CHANNELS_DEF = 6;

  localparam int unsigned BRIGHT_W   = 12;
  localparam int unsigned POWER_W    = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned STORED_ENTRIES = 16;
  localparam int unsigned JOB_DEPTH  = 4;

  localparam logic [11:0]       REG_FULL  = 12'd4095;
  localparam logic [63:0]       DENOM_SQ  = 64'd16769025;
  localparam logic [23:0]       POWER_MAX = 24'hFFFFFF;
  localparam logic [13:0]       SCALE_E4  = 14'd10000;
  localparam logic [6:0]        SCALE_E2  = 7'd100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOARD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAX  = 2'd3;

  typedef enum logic [1:0] {
    VENDOR_A = 2'd0,
    VENDOR_B = 2'd1,
    VENDOR_C = 2'd2,
    VENDOR_D = 2'd3
  } vendor_e;

  // one division job handed from the front to the back
  typedef struct packed {
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] den;
    logic              low;
    logic              zero;
  } bpe_job_t;

  localparam logic [14:0] VOLT_MV [4][16] = '{
    '{15'd19800, 15'd19800, 15'd19800, 15'd19800, 15'd19900, 15'd20000, 15'd20100, 15'd20200,
      15'd20300, 15'd20400, 15'd20500, 15'd20530, 15'd20530, 15'd20530, 15'd20530, 15'd20530},
    '{15'd19700, 15'd19700, 15'd19700, 15'd19700, 15'd19800, 15'd19900, 15'd20000, 15'd20100,
      15'd20200, 15'd20270, 15'd20300, 15'd20300, 15'd20300, 15'd20300, 15'd20300, 15'd20300},
    '{15'd19670, 15'd19670, 15'd19670, 15'd19670, 15'd19770, 15'd19930, 15'd20030, 15'd20130,
      15'd20200, 15'd20270, 15'd20370, 15'd20370, 15'd20370, 15'd20370, 15'd20370, 15'd20370},
    '{15'd19720, 15'd19720, 15'd19720, 15'd19720, 15'd19820, 15'd19940, 15'd20040, 15'd20140,
      15'd20230, 15'd20310, 15'd20390, 15'd20400, 15'd20400, 15'd20400, 15'd20400, 15'd20400}
  };

  localparam logic [13:0] EFF_E4 [16] = '{
    14'd6680, 14'd7784, 14'd8240, 14'd8484, 14'd8634, 14'd8723, 14'd8807, 14'd8860,
    14'd8889, 14'd8915, 14'd8953, 14'd8983, 14'd9003, 14'd9034, 14'd9049, 14'd9060
  };

  function automatic vendor_e vendor_of(logic [7:0] id);
    vendor_e v;
    case (id)
      8'd2, 8'd5, 8'd6: v = VENDOR_A;
      8'd3:             v = VENDOR_B;
      8'd1, 8'd4:       v = VENDOR_C;
      default:          v = VENDOR_D;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] imax_ma(logic [2:0] idx);
    logic [5:0] v;
    case (idx)
      3'd0: v = 6'd5;
      3'd1: v = 6'd10;
      3'd2: v = 6'd15;
      3'd3: v = 6'd20;
      3'd4: v = 6'd23;
      3'd5: v = 6'd25;
      3'd6: v = 6'd30;
      default: v = 6'd50;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] slope_tenths(vendor_e c);
    logic [7:0] v;
    case (c)
      VENDOR_A: v = 8'd224;
      VENDOR_B: v = 8'd221;
      default:  v = 8'd222;
    endcase
    return v;
  endfunction

  function automatic logic [13:0] icpt_tenths(vendor_e c);
    logic [13:0] v;
    case (c)
      VENDOR_A: v = 14'd12360;
      VENDOR_B: v = 14'd14310;
      VENDOR_C: v = 14'd13190;
      default:  v = 14'd13290;
    endcase
    return v;
  endfunction

  function automatic logic [14:0] volt_mv(vendor_e c, logic [3:0] idx);
    return VOLT_MV[c][idx];
  endfunction

  function automatic logic [13:0] eff_e4(logic [3:0] idx);
    return EFF_E4[idx];
  endfunction

endpackage

// File: rtl/core/backlight_power_estimator.sv
// backlight power estimator, top level: configuration registers, front, queue, back
// uses bpe_pkg, bpe_front, bpe_fifo, bpe_back and the assertion macro header
//
// usage:
//   input channel in_valid_i/in_ready_o carries one 12-bit brightness code per transfer
//   output channel out_valid_o/out_ready_i returns power in microwatts and the
//   low-region flag, one result per input, in input order
//   config channel cfg_valid_i/cfg_ready_o writes register cfg_index_i with cfg_data_i
//   (0 board enable, 1 panel id, 2 current scale, 3 max-current index); always ready,
//   write only while no item is in flight
// throughput: one item per cycle unless the receiver holds off; each stage of front,
//   queue and back passes one item; pipeline: 8 front stages, the job queue, two
//   64-stage dividers with 2 glue stages, and the output register
// reset: configuration registers read zero, pipelines empty, result zero until enabled
// stalls: when the receiver holds off, the back pipeline freezes; the queue then
//   fills and the front freezes, which drops in_ready_o; no item is lost
`include "backlight_power_estimator_macros.svh"
module backlight_power_estimator import bpe_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES   = TABLE_ENTRIES_DEF,
  parameter int unsigned TABLE_STEP      = TABLE_STEP_DEF,
  parameter int unsigned DRIVER_CHANNELS = DRIVER_CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [BRIGHT_W-1:0]   brightness_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POWER_W-1:0]    power_microwatts_o,
  output logic                  low_region_o
);

  logic        board_supported_q;
  logic [7:0]  panel_id_q;
  logic [11:0] current_scale_q;
  logic [2:0]  max_current_index_q;

  logic     fj_valid, fj_ready, bj_valid, bj_ready;
  bpe_job_t fj, bj;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_supported_q   <= 1'b0;
      panel_id_q          <= '0;
      current_scale_q     <= '0;
      max_current_index_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BOARD: board_supported_q   <= cfg_data_i[0];
        REG_PANEL: panel_id_q          <= cfg_data_i[7:0];
        REG_SCALE: current_scale_q     <= cfg_data_i;
        REG_IMAX:  max_current_index_q <= cfg_data_i[2:0];
        default:   board_supported_q   <= board_supported_q;
      endcase
    end
  end

  // region choice and table interpolation
  bpe_front #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .TABLE_STEP      (TABLE_STEP),
    .DRIVER_CHANNELS (DRIVER_CHANNELS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .brightness_i        (brightness_i),
    .board_supported_i   (board_supported_q),
    .panel_id_i          (panel_id_q),
    .current_scale_i     (current_scale_q),
    .max_current_index_i (max_current_index_q),
    .job_valid_o         (fj_valid),
    .job_ready_i         (fj_ready),
    .job_o               (fj)
  );

  // job queue
  bpe_fifo #(.DEPTH(JOB_DEPTH)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_data_o   (bj)
  );

  // division and output
  bpe_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .job_valid_i        (bj_valid),
    .job_ready_o        (bj_ready),
    .job_i              (bj),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .power_microwatts_o (power_microwatts_o),
    .low_region_o       (low_region_o)
  );

  // a disabled board yields zero power and never the low-region flag
  `BPE_ASSERT(a_off_zero, clk_i, rst_ni, (out_valid_o && !board_supported_q) |-> (power_microwatts_o == '0 && !low_region_o))
  `BPE_ASSERT_NEVER(a_low_needs_board, clk_i, rst_ni, out_valid_o && low_region_o && !board_supported_q)
  // the front only stalls when its job cannot enter the queue
  `BPE_ASSERT(a_front_stall, clk_i, rst_ni, !in_ready_o |-> (fj_valid && !fj_ready))

endmodule

// File: rtl/core/bpe_front.sv
// front pipeline: takes brightness codes, picks the region, interpolates the tables
// and builds one numerator/denominator job per item; uses bpe_pkg
module bpe_front import bpe_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES   = TABLE_ENTRIES_DEF,
  parameter int unsigned TABLE_STEP      = TABLE_STEP_DEF,
  parameter int unsigned DRIVER_CHANNELS = DRIVER_CHANNELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [BRIGHT_W-1:0] brightness_i,
  input  logic                board_supported_i,
  input  logic [7:0]          panel_id_i,
  input  logic [11:0]         current_scale_i,
  input  logic [2:0]          max_current_index_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output bpe_job_t            job_o
);

  localparam int unsigned USED = (TABLE_ENTRIES < STORED_ENTRIES) ? TABLE_ENTRIES
                                                                   : STORED_ENTRIES;
  localparam logic [3:0]  LAST    = 4'(USED - 1);
  localparam logic [11:0] USED_C  = 12'(USED);
  localparam int unsigned RECIP   = (1 << 24) / TABLE_STEP;
  localparam logic [24:0] RECIP_C = 25'(RECIP);
  localparam logic [11:0] STEP_C  = 12'(TABLE_STEP);
  localparam logic [4:0]  CH_C    = 5'(DRIVER_CHANNELS);

  logic f_en;
  logic [7:0] v_q;

  // stage 1 registers
  logic [11:0] s1_b_q, s1_cs_q, s1_west_q;
  vendor_e     s1_cls_q;
  logic        s1_sup_q;
  logic [10:0] s1_chi_q;
  // stage 2 registers
  logic [11:0] s2_b_q, s2_west_q;
  vendor_e     s2_cls_q;
  logic        s2_sup_q, s2_low_q, s2_full_q;
  logic [12:0] s2_rem_q;
  logic [22:0] s2_cur_q;
  logic [20:0] s2_fit_q;
  // stage 3 registers
  logic [11:0] s3_whole_q, s3_rem_q;
  vendor_e     s3_cls_q;
  logic        s3_sup_q, s3_low_q, s3_full_q;
  logic [34:0] s3_curb_q;
  logic [43:0] s3_lowp_q;
  // stage 4 registers
  logic [14:0] s4_lov_q;
  logic [13:0] s4_loe_q;
  logic signed [16:0] s4_dv_q, s4_de_q;
  logic [11:0] s4_rem_q;
  logic [34:0] s4_curb_q;
  logic [63:0] s4_lowp_q;
  logic        s4_sup_q, s4_low_q;
  // stage 5 registers
  logic [27:0] s5_av_q, s5_ae_q;
  logic signed [29:0] s5_bv_q, s5_be_q;
  logic [34:0] s5_curb_q;
  logic [63:0] s5_lowp_q;
  logic        s5_sup_q, s5_low_q;
  // stage 6 registers
  logic [31:0] s6_vnum_q, s6_enum_q;
  logic [34:0] s6_curb_q;
  logic [63:0] s6_lowp_q;
  logic        s6_sup_q, s6_low_q;
  // stage 7 registers
  logic [48:0] s7_p0_q;
  logic [49:0] s7_p1_q;
  logic [63:0] s7_d_q, s7_lowp_q;
  logic        s7_sup_q, s7_low_q;
  // stage 8 register
  bpe_job_t    s8_job_q;

  // combinational terms per stage
  logic [36:0] west_prod;
  logic [23:0] whole_prod;
  logic [11:0] whole_c, rem_c;
  logic        use_last;
  logic [3:0]  lo_i, hi_i;
  logic [14:0] hiv;
  logic [13:0] hie;
  logic signed [31:0] vsum, esum;
  logic [63:0] x_c;

  assign f_en        = !v_q[7] || job_ready_i;
  assign in_ready_o  = f_en;
  assign job_valid_o = v_q[7];
  assign job_o       = s8_job_q;

  always_comb begin
    west_prod  = 37'(brightness_i) * 37'(RECIP_C);
    whole_prod = 24'(s1_west_q) * 24'(STEP_C);
    // reciprocal estimate is at most one short
    if (s2_rem_q >= 13'(STEP_C)) begin
      whole_c = s2_west_q + 12'd1;
      rem_c   = 12'(s2_rem_q - 13'(STEP_C));
    end else begin
      whole_c = s2_west_q;
      rem_c   = 12'(s2_rem_q);
    end
    // table point selection
    use_last = s3_full_q || (s3_whole_q == 12'd0) || (s3_whole_q >= USED_C);
    lo_i = use_last ? LAST : 4'(s3_whole_q - 12'd1);
    hi_i = use_last ? LAST : s3_whole_q[3:0];
    hiv  = volt_mv(s3_cls_q, hi_i);
    hie  = eff_e4(hi_i);
    vsum = 32'(signed'({4'b0, s5_av_q})) + 32'(s5_bv_q);
    esum = 32'(signed'({4'b0, s5_ae_q})) + 32'(s5_be_q);
    x_c  = 64'(s7_p0_q) + (64'(s7_p1_q) << 17);
  end

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (f_en) begin
      v_q <= {v_q[6:0], in_valid_i};
    end
  end

  // front payload pipeline
  always_ff @(posedge clk_i) begin
    if (f_en) begin
      s1_b_q    <= brightness_i;
      s1_cls_q  <= vendor_of(panel_id_i);
      s1_sup_q  <= board_supported_i;
      s1_cs_q   <= current_scale_i;
      s1_chi_q  <= 11'(CH_C) * 11'(imax_ma(max_current_index_i));
      s1_west_q <= 12'(west_prod >> 24);

      s2_b_q    <= s1_b_q;
      s2_west_q <= s1_west_q;
      s2_cls_q  <= s1_cls_q;
      s2_sup_q  <= s1_sup_q;
      s2_low_q  <= (s1_b_q < STEP_C);
      s2_full_q <= (s1_b_q == REG_FULL);
      s2_rem_q  <= 13'(24'(s1_b_q) - whole_prod);
      s2_cur_q  <= 23'(s1_cs_q) * 23'(s1_chi_q);
      s2_fit_q  <= 21'(slope_tenths(s1_cls_q)) * 21'(s1_b_q) + 21'(icpt_tenths(s1_cls_q));

      s3_whole_q <= whole_c;
      s3_rem_q   <= rem_c;
      s3_cls_q   <= s2_cls_q;
      s3_sup_q   <= s2_sup_q;
      s3_low_q   <= s2_low_q;
      s3_full_q  <= s2_full_q;
      s3_curb_q  <= 35'(s2_cur_q) * 35'(s2_b_q);
      s3_lowp_q  <= 44'(s2_fit_q) * 44'(s2_cur_q);

      s4_lov_q  <= volt_mv(s3_cls_q, lo_i);
      s4_loe_q  <= eff_e4(lo_i);
      s4_dv_q   <= signed'({2'b0, hiv}) - signed'({2'b0, volt_mv(s3_cls_q, lo_i)});
      s4_de_q   <= signed'({3'b0, hie}) - signed'({3'b0, eff_e4(lo_i)});
      s4_rem_q  <= s3_rem_q;
      s4_curb_q <= s3_curb_q;
      s4_lowp_q <= 64'(s3_lowp_q) * 64'(SCALE_E2);
      s4_sup_q  <= s3_sup_q;
      s4_low_q  <= s3_low_q;

      s5_av_q   <= 28'(s4_lov_q) * 28'(STEP_C);
      s5_ae_q   <= 28'(s4_loe_q) * 28'(STEP_C);
      s5_bv_q   <= 30'(s4_dv_q) * 30'(signed'({1'b0, s4_rem_q}));
      s5_be_q   <= 30'(s4_de_q) * 30'(signed'({1'b0, s4_rem_q}));
      s5_curb_q <= s4_curb_q;
      s5_lowp_q <= s4_lowp_q;
      s5_sup_q  <= s4_sup_q;
      s5_low_q  <= s4_low_q;

      s6_vnum_q <= 32'(unsigned'(vsum));
      s6_enum_q <= 32'(unsigned'(esum));
      s6_curb_q <= s5_curb_q;
      s6_lowp_q <= s5_lowp_q;
      s6_sup_q  <= s5_sup_q;
      s6_low_q  <= s5_low_q;

      // split the wide product into two partial products
      s7_p0_q   <= 49'(s6_vnum_q) * 49'(s6_curb_q[16:0]);
      s7_p1_q   <= 50'(s6_vnum_q) * 50'(s6_curb_q[34:17]);
      s7_d_q    <= 64'(s6_enum_q) * DENOM_SQ;
      s7_lowp_q <= s6_lowp_q;
      s7_sup_q  <= s6_sup_q;
      s7_low_q  <= s6_low_q;

      s8_job_q.zero <= !s7_sup_q;
      s8_job_q.low  <= s7_sup_q && s7_low_q;
      if (s7_low_q) begin
        s8_job_q.num <= s7_lowp_q;
        s8_job_q.den <= DENOM_SQ;
      end else begin
        s8_job_q.num <= x_c;
        s8_job_q.den <= (s7_d_q == 64'd0) ? 64'd1 : s7_d_q;
      end
    end
  end

endmodule

// File: rtl/core/bpe_fifo.sv
// short job queue between the front and the back pipelines
// uses bpe_pkg for the job type
module bpe_fifo import bpe_pkg::*; #(
  parameter int unsigned DEPTH = JOB_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  bpe_job_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output bpe_job_t pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bpe_job_t          mem_q [DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [PW:0]       cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != (PW+1)'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/bpe_divider.sv
// pipelined restoring divider, one quotient bit per stage, with a sideband
// no package dependencies
module bpe_divider #(
  parameter int unsigned W  = 64,
  parameter int unsigned SW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W-1:0]  quot_o,
  output logic [W-1:0]  rem_o,
  output logic [W-1:0]  den_o,
  output logic [SW-1:0] side_o
);

  typedef struct packed {
    logic [W-1:0]  rem;
    logic [W-1:0]  num;
    logic [W-1:0]  quo;
    logic [W-1:0]  den;
    logic [SW-1:0] side;
  } dstage_t;

  dstage_t      st_q [W];
  dstage_t      st_d [W];
  logic [W-1:0] v_q;

  // one compare and subtract per stage
  always_comb begin
    dstage_t    src;
    logic [W:0] trial;
    for (int i = 0; i < W; i++) begin
      if (i == 0) begin
        src.rem  = '0;
        src.num  = num_i;
        src.quo  = '0;
        src.den  = den_i;
        src.side = side_i;
      end else begin
        src = st_q[i-1];
      end
      trial = {src.rem, src.num[W-1]};
      st_d[i].num  = src.num << 1;
      st_d[i].den  = src.den;
      st_d[i].side = src.side;
      if (trial >= {1'b0, src.den}) begin
        st_d[i].rem = W'(trial - {1'b0, src.den});
        st_d[i].quo = {src.quo[W-2:0], 1'b1};
      end else begin
        st_d[i].rem = trial[W-1:0];
        st_d[i].quo = {src.quo[W-2:0], 1'b0};
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[W-2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < W; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign valid_o = v_q[W-1];
  assign quot_o  = st_q[W-1].quo;
  assign rem_o   = st_q[W-1].rem;
  assign den_o   = st_q[W-1].den;
  assign side_o  = st_q[W-1].side;

endmodule

// File: rtl/core/bpe_back.sv
// back pipeline: divides each job, rescales the remainder to 1/10000 and
// divides again, then saturates into the output register; uses bpe_pkg, bpe_divider
module bpe_back import bpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  bpe_job_t           job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [POWER_W-1:0] power_microwatts_o,
  output logic               low_region_o
);

  localparam int unsigned SIDE2_W = 38 + 1 + POWER_W + 2;

  logic b_en;

  logic              d1_v;
  logic [WORD_W-1:0] d1_q, d1_r, d1_d;
  logic [1:0]        d1_side;

  logic              m_v_q;
  logic [45:0]       m_plo_q;
  logic [31:0]       m_phi_q;
  logic [WORD_W-1:0] m_d_q;
  logic              m_sat_q, m_low_q, m_zero_q;
  logic [POWER_W-1:0] m_q1_q;

  logic              a_v_q;
  logic [WORD_W-1:0] a_r2_q, a_d_q;
  logic [SIDE2_W-1:0] a_side_q;

  logic              d2_v;
  logic [WORD_W-1:0] d2_q, d2_r, d2_d;
  logic [SIDE2_W-1:0] d2_side;

  logic [37:0]        f_q1x;
  logic               f_sat, f_low, f_zero;
  logic [POWER_W-1:0] f_q1;
  logic [64:0]        f_sum;
  logic [POWER_W-1:0] f_pow;

  logic               out_v_q;
  logic [POWER_W-1:0] pow_q;
  logic               low_q;

  assign b_en        = !out_v_q || out_ready_i;
  assign job_ready_o = b_en;

  // whole part of the quotient
  bpe_divider #(.W(WORD_W), .SW(2)) u_div_whole (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (b_en),
    .valid_i (job_valid_i),
    .num_i   (job_i.num),
    .den_i   (job_i.den),
    .side_i  ({job_i.low, job_i.zero}),
    .valid_o (d1_v),
    .quot_o  (d1_q),
    .rem_o   (d1_r),
    .den_o   (d1_d),
    .side_o  (d1_side)
  );

  // remainder times 10000 in two partial products, kept modulo 2^64
  always_ff @(posedge clk_i) begin
    if (b_en) begin
      m_plo_q  <= 46'(d1_r[31:0]) * 46'(SCALE_E4);
      m_phi_q  <= 32'(d1_r[63:32] * 32'(SCALE_E4));
      m_d_q    <= d1_d;
      m_sat_q  <= (d1_q > 64'(POWER_MAX));
      m_q1_q   <= d1_q[POWER_W-1:0];
      m_low_q  <= d1_side[1];
      m_zero_q <= d1_side[0];
      a_r2_q   <= 64'(m_plo_q) + {m_phi_q, 32'b0};
      a_d_q    <= m_d_q;
      a_side_q <= {38'(m_q1_q) * 38'(SCALE_E4), m_sat_q, m_q1_q, m_low_q, m_zero_q};
    end
  end

  // fractional part in units of 1/10000
  bpe_divider #(.W(WORD_W), .SW(SIDE2_W)) u_div_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (b_en),
    .valid_i (a_v_q),
    .num_i   (a_r2_q),
    .den_i   (a_d_q),
    .side_i  (a_side_q),
    .valid_o (d2_v),
    .quot_o  (d2_q),
    .rem_o   (d2_r),
    .den_o   (d2_d),
    .side_o  (d2_side)
  );

  // combine and saturate
  always_comb begin
    {f_q1x, f_sat, f_q1, f_low, f_zero} = d2_side;
    f_sum = 65'(f_q1x) + 65'(d2_q);
    if (f_zero) begin
      f_pow = '0;
    end else if (f_sat) begin
      f_pow = POWER_MAX;
    end else if (f_low) begin
      f_pow = f_q1;
    end else if (f_sum > 65'(POWER_MAX)) begin
      f_pow = POWER_MAX;
    end else begin
      f_pow = f_sum[POWER_W-1:0];
    end
  end

  // valid bits of the glue stages and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q   <= 1'b0;
      a_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (b_en) begin
      m_v_q   <= d1_v;
      a_v_q   <= m_v_q;
      out_v_q <= d2_v;
    end
  end

  // output register; the remainder and divisor of the last divide feed the low-region flag
  always_ff @(posedge clk_i) begin
    if (b_en && d2_v) begin
      pow_q <= f_pow;
      low_q <= f_low && !f_zero && (d2_r != d2_d);
    end
  end

  assign out_valid_o        = out_v_q;
  assign power_microwatts_o = pow_q;
  assign low_region_o       = low_q;

endmodule

// File: dv/backlight_power_estimator_tb.sv
// testbench for the backlight power estimator: random and directed brightness codes
// over several register settings, checked against an in-bench power predictor
// depends on bpe_pkg and the backlight_power_estimator top level
module backlight_power_estimator_tb;
  import bpe_pkg::*;

  localparam int unsigned STEP = TABLE_STEP_DEF;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct {
    logic [POWER_W-1:0] power;
    logic               low;
  } power_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_BOARD;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [BRIGHT_W-1:0]   brightness_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [POWER_W-1:0]    power_microwatts_o;
  logic                  low_region_o;

  // register shadow used by the predictor
  logic        board_en = 1'b0;
  logic [7:0]  panel = '0;
  logic [11:0] scale = '0;
  logic [2:0]  imax_idx = '0;

  logic [BRIGHT_W-1:0] bright_q[$];
  power_t              expected_q[$];
  int unsigned         errors = 0;
  int unsigned         send_gap = 0;
  int unsigned         recv_stall = 0;
  logic                no_idle = 1'b0;
  logic                hold_off = 1'b0;

  backlight_power_estimator dut (.*);

  always #2 clk_i = ~clk_i;

  // per-vendor linear fit coefficients in tenths
  function automatic longint unsigned fit_slope(vendor_e v);
    case (v)
      VENDOR_A: return 224;
      VENDOR_B: return 221;
      default:  return 222;
    endcase
  endfunction

  function automatic longint unsigned fit_icpt(vendor_e v);
    case (v)
      VENDOR_A: return 12360;
      VENDOR_B: return 14310;
      VENDOR_C: return 13190;
      default:  return 13290;
    endcase
  endfunction

  function automatic vendor_e panel_vendor(logic [7:0] id);
    if (id == 8'd2 || id == 8'd5 || id == 8'd6) return VENDOR_A;
    if (id == 8'd3) return VENDOR_B;
    if (id == 8'd1 || id == 8'd4) return VENDOR_C;
    return VENDOR_D;
  endfunction

  function automatic longint unsigned max_ma(logic [2:0] idx);
    case (idx)
      3'd0: return 5;
      3'd1: return 10;
      3'd2: return 15;
      3'd3: return 20;
      3'd4: return 23;
      3'd5: return 25;
      3'd6: return 30;
      default: return 50;
    endcase
  endfunction

  // table value interpolated at code b, scaled by the table step
  function automatic longint unsigned lerp_scaled(longint tab[16], logic [11:0] b);
    longint whole, rem;
    whole = b / STEP;
    rem = b % STEP;
    if (b == REG_FULL || whole == 0 || whole >= 16) return tab[15] * STEP;
    if (b == STEP) return tab[0] * STEP;
    return tab[whole-1] * STEP + (tab[whole] - tab[whole-1]) * rem;
  endfunction

  function automatic power_t predict_power(logic [11:0] b);
    power_t r;
    vendor_e v;
    longint volt[16], eff[16];
    longint unsigned cur, fit, x, d, q, rm, p;
    v = panel_vendor(panel);
    cur = longint'(DRIVER_CHANNELS_DEF) * scale * max_ma(imax_idx);
    r.power = '0;
    r.low = 1'b0;
    if (!board_en) return r;
    if (b < STEP) begin
      fit = fit_slope(v) * b + fit_icpt(v);
      p = fit * cur * 100 / DENOM_SQ;
      r.power = (p > POWER_MAX) ? POWER_MAX : p[23:0];
      r.low = 1'b1;
      return r;
    end
    for (int i = 0; i < 16; i++) begin
      volt[i] = VOLT_MV[v][i];
      eff[i] = EFF_E4[i];
    end
    x = lerp_scaled(volt, b) * (cur * b);
    d = lerp_scaled(eff, b) * DENOM_SQ;
    if (d == 0) d = 1;
    q = x / d;
    rm = x % d;
    if (q > POWER_MAX) p = POWER_MAX;
    else begin
      p = q * 10000 + (rm * 10000) / d;
      if (p > POWER_MAX) p = POWER_MAX;
    end
    r.power = p[23:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // input driver: sends queued codes, predicts each accepted transfer
  always @(posedge clk_i) begin
    int unsigned g;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(predict_power(brightness_i));
        g = no_idle ? 0 : $urandom_range(0, 3);
        if (g == 0 && bright_q.size() != 0) begin
          brightness_i <= bright_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          send_gap <= g;
        end
      end else if (!in_valid_i) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (bright_q.size() != 0) begin
          brightness_i <= bright_q.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // result monitor: compares each transfer with the oldest prediction
  always @(posedge clk_i) begin
    int unsigned s;
    power_t want;
    if (rst_ni) begin
      s = recv_stall;
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with none pending, power", power_microwatts_o, 0);
        end else begin
          want = expected_q.pop_front();
          if (power_microwatts_o !== want.power)
            report_mismatch("power_microwatts", power_microwatts_o, want.power);
          if (low_region_o !== want.low)
            report_mismatch("low_region", low_region_o, want.low);
        end
        s = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
        recv_stall <= s;
      end else if (s > 0) begin
        out_ready_i <= 1'b0;
        recv_stall <= s - 1;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall <= 0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_BOARD: board_en = data[0];
      REG_PANEL: panel = data[7:0];
      REG_SCALE: scale = data;
      default:   imax_idx = data[2:0];
    endcase
  endtask

  task automatic set_regs(logic en, logic [7:0] id, logic [11:0] sc, logic [2:0] im);
    write_reg(REG_BOARD, {11'd0, en});
    write_reg(REG_PANEL, {4'd0, id});
    write_reg(REG_SCALE, sc);
    write_reg(REG_IMAX, {9'd0, im});
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (bright_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_random(int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 4) bright_q.push_back(12'($urandom_range(0, STEP - 1)));
      else bright_q.push_back(12'($urandom_range(0, 4095)));
    end
  endtask

  // directed codes around region and table boundaries
  task automatic push_directed();
    logic [11:0] codes[$] = '{12'd0, 12'd1, 12'd272, 12'd273, 12'd274, 12'd545, 12'd546,
                              12'd547, 12'd2048, 12'd2730, 12'd3822, 12'd4094, 12'd4095,
                              12'd2730, 12'd1365};
    foreach (codes[i]) bright_q.push_back(codes[i]);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // unsupported board answers zero
    set_regs(1'b0, 8'd2, 12'd4095, 3'd7);
    push_directed();
    push_random(20);
    drain();
    // full current for vendor classes A and B, then class C at reduced current
    set_regs(1'b1, 8'd2, 12'd4095, 3'd7);
    push_directed();
    drain();
    set_regs(1'b1, 8'd3, 12'd4095, 3'd7);
    push_directed();
    push_random(40);
    drain();
    set_regs(1'b1, 8'd1, 12'd2048, 3'd4);
    push_directed();
    drain();
    // zero current scale gives zero power
    set_regs(1'b1, 8'd255, 12'd0, 3'd0);
    push_directed();
    push_random(20);
    drain();
    // back-to-back stretch with a long receiver hold-off; more items than the
    // pipeline holds, so the queue fills and the input stalls
    set_regs(1'b1, 8'd4, 12'd1, 3'd0);
    no_idle <= 1'b1;
    push_random(180);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
    drain();
    no_idle <= 1'b0;
    // random register settings
    repeat (6) begin
      set_regs(1'b1, ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7))
                                                 : 8'($urandom_range(0, 255)),
               12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7)));
      push_random(28);
      drain();
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bpe_pkg.sv
rtl/core/bpe_front.sv
rtl/core/bpe_fifo.sv
rtl/core/bpe_divider.sv
rtl/core/bpe_back.sv
rtl/core/backlight_power_estimator.sv
dv/backlight_power_estimator_tb.sv
